[src/nsth_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nsth_pkg
// constants and round function of the nibble spn truncated hash
// ----------------------------------------------------------------------------
package nsth_pkg;

   localparam int BLOCK_W  = 64;
   localparam int DIGEST_W = 32;
   localparam int NIB_W    = 4;
   localparam int NIBBLES  = 16;
   localparam int ROUNDS   = 4;

   // key nibbles of the last round, nibbles 8..11 = f,3,3,f
   localparam logic [BLOCK_W-1:0] LAST_ROUND_KEY = 64'h0000_f33f_0000_0000;

   typedef logic [NIB_W-1:0]   nibble_type;
   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [DIGEST_W-1:0] digest_type;

   // 4-bit substitution box
   function automatic nibble_type sbox(input nibble_type v);
      nibble_type r;
      case (v)
         4'h0: r = 4'ha;
         4'h1: r = 4'h5;
         4'h2: r = 4'h4;
         4'h3: r = 4'h2;
         4'h4: r = 4'h6;
         4'h5: r = 4'h1;
         4'h6: r = 4'hf;
         4'h7: r = 4'h3;
         4'h8: r = 4'hb;
         4'h9: r = 4'he;
         4'ha: r = 4'h7;
         4'hb: r = 4'h0;
         4'hc: r = 4'h8;
         4'hd: r = 4'hd;
         4'he: r = 4'hc;
         4'hf: r = 4'h9;
         default: r = 4'h0;
      endcase
      return r;
   endfunction

   // one round: key xor (last round only), substitution, row rotation, column mix
   function automatic block_type spn_round(input block_type s_in, input logic last);
      block_type  x;
      block_type  o;
      nibble_type s [NIBBLES];
      nibble_type t [NIBBLES];
      int         i;
      int         r;
      int         c;
      x = last ? (s_in ^ LAST_ROUND_KEY) : s_in;
      for (i = 0; i < NIBBLES; i++) begin
         s[i] = sbox(x[NIB_W*i +: NIB_W]);
      end
      // row r rotates left by r nibbles
      for (r = 0; r < 4; r++) begin
         for (c = 0; c < 4; c++) begin
            t[4*r + c] = s[4*r + ((c + r) & 3)];
         end
      end
      o = '0;
      for (c = 0; c < 4; c++) begin
         o[NIB_W*c        +: NIB_W] = t[c]     ^ t[4 + c];
         o[NIB_W*(4 + c)  +: NIB_W] = t[c]     ^ t[8 + c];
         o[NIB_W*(8 + c)  +: NIB_W] = t[4 + c] ^ t[8 + c];
         o[NIB_W*(12 + c) +: NIB_W] = t[4 + c] ^ t[12 + c];
      end
      return o;
   endfunction

endpackage
`default_nettype wire

[src/nibble_spn_truncated_hash_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nibble_spn_truncated_hash_unit
// four-round nibble spn over a 64-bit block, 32-bit truncated digest out
// ----------------------------------------------------------------------------
// the input block is registered, then the round chain runs and the digest is registered
// throughput: one item per cycle; busy is always low, the unit never stalls
// the receiver cannot stall, so every result is shown for exactly one cycle
// reset (synchronous, active high) clears the valid pipeline; no item in flight
// ----------------------------------------------------------------------------
module nibble_spn_truncated_hash_unit (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire  [nsth_pkg::BLOCK_W-1:0]  req_block_in,
   output logic                     rsp_strobe,
   output logic [nsth_pkg::DIGEST_W-1:0] rsp_digest
);

   // input stage
   logic                  in_valid_ff;
   logic                  in_valid_in;
   nsth_pkg::block_type   in_block_ff;

   // result stage
   logic                  out_valid_ff;
   nsth_pkg::digest_type  out_digest_ff;
   nsth_pkg::digest_type  out_digest_in;

   // round chain between the two registers
   nsth_pkg::block_type   round_state [nsth_pkg::ROUNDS+1];

   // the pipeline takes an item every cycle
   assign busy        = 1'b0;
   assign in_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload capture, no reset needed
   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_block_ff <= req_block_in;
      end
   end

   // four unrolled rounds; only the last one xors in its key
   always_comb begin
      round_state[0] = in_block_ff;
      for (int k = 0; k < nsth_pkg::ROUNDS; k++) begin
         round_state[k+1] = nsth_pkg::spn_round(round_state[k],
                                                (k == nsth_pkg::ROUNDS - 1));
      end
      // truncation keeps nibbles 0..7
      out_digest_in = round_state[nsth_pkg::ROUNDS][nsth_pkg::DIGEST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         out_digest_ff <= out_digest_in;
      end
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_digest = out_digest_ff;

endmodule
`default_nettype wire
